[rtl/bpfa_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the bitmap page frame allocator.
// Used by bpfa_ram, bpfa_ctrl, bpfa_datapath and bitmap_page_frame_allocator.
package bpfa_pkg;

    localparam int FRAMES_DEF    = 65536;
    localparam int ADDR_W        = 48;
    localparam int FRAME_SHIFT   = 12;
    localparam int FRAME_MASK    = 4095;
    localparam int PN_W          = ADDR_W - FRAME_SHIFT;
    localparam int LP_W          = ADDR_W + 1 - FRAME_SHIFT;
    localparam int MAP_W         = 64;
    localparam int BIT_W         = 6;
    localparam int MAP_WORDS_DEF = (FRAMES_DEF + MAP_W - 1) / MAP_W;
    localparam int OUT_CNT_W     = 17;
    localparam int MODE_W        = 2;
    localparam int STATUS_W      = 2;
    localparam int CFG_IDX_W     = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_RAM_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAM_SIZE = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_INIT    = 2'd0,
        MODE_RESERVE = 2'd1,
        MODE_ALLOC   = 2'd2,
        MODE_FREE    = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE      = 2'd0,
        STAT_NONE_FREE = 2'd1,
        STAT_REJECTED  = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_INIT_SET,
        ST_CLEAR,
        ST_RSV_SUM,
        ST_RSV_CLIP,
        ST_RSV_OFF,
        ST_RSV_LIM,
        ST_RSV_CHK,
        ST_ALC_CHK,
        ST_FRE_OFF,
        ST_FRE_CHK,
        ST_PRIME,
        ST_WALK,
        ST_RSV_ACC,
        ST_RSV_COMMIT,
        ST_PAGE,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic load_in;
        logic init_set;
        logic clr_word;
        logic rsv_sum;
        logic rsv_clip;
        logic rsv_off;
        logic rsv_lim;
        logic rsv_chk;
        logic alc_chk;
        logic fre_off;
        logic fre_chk;
        logic prime;
        logic walk;
        logic rsv_commit;
        logic page_calc;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic last_word;
        logic hit;
        logic clr_last;
    } stat_t;

endpackage

[rtl/bpfa_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Depends on bpfa_pkg for the default width and depth.
module bpfa_ram #(
    parameter int WIDTH = bpfa_pkg::MAP_W,
    parameter int DEPTH = bpfa_pkg::MAP_WORDS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/bpfa_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer of the allocator: handshakes, per-mode step order, result hand-off.
// Depends on bpfa_pkg; drives bpfa_datapath through cmd_t, reads stat_t.
module bpfa_ctrl (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [bpfa_pkg::MODE_W-1:0]    s_mode,
    output logic                           m_valid,
    input  logic                           m_ready,
    output bpfa_pkg::cmd_t                 cmd,
    input  bpfa_pkg::stat_t                stat
);

    bpfa_pkg::state_t state_reg, state_next;
    bpfa_pkg::mode_t  mode_reg, mode_next;
    logic             m_valid_reg, m_valid_next;
    logic             out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bpfa_pkg::ST_IDLE: begin
                if (s_valid) begin
                    case (bpfa_pkg::mode_t'(s_mode))
                        bpfa_pkg::MODE_INIT:    state_next = bpfa_pkg::ST_INIT_SET;
                        bpfa_pkg::MODE_RESERVE: state_next = bpfa_pkg::ST_RSV_SUM;
                        bpfa_pkg::MODE_ALLOC:   state_next = bpfa_pkg::ST_ALC_CHK;
                        default:                state_next = bpfa_pkg::ST_FRE_OFF;
                    endcase
                end
            end
            bpfa_pkg::ST_INIT_SET: state_next = bpfa_pkg::ST_CLEAR;
            bpfa_pkg::ST_CLEAR: begin
                if (stat.clr_last) begin
                    state_next = bpfa_pkg::ST_RESP;
                end
            end
            bpfa_pkg::ST_RSV_SUM:  state_next = bpfa_pkg::ST_RSV_CLIP;
            bpfa_pkg::ST_RSV_CLIP: state_next = bpfa_pkg::ST_RSV_OFF;
            bpfa_pkg::ST_RSV_OFF:  state_next = bpfa_pkg::ST_RSV_LIM;
            bpfa_pkg::ST_RSV_LIM:  state_next = bpfa_pkg::ST_RSV_CHK;
            bpfa_pkg::ST_RSV_CHK:  state_next = bpfa_pkg::ST_PRIME;
            bpfa_pkg::ST_ALC_CHK:  state_next = bpfa_pkg::ST_PRIME;
            bpfa_pkg::ST_FRE_OFF:  state_next = bpfa_pkg::ST_FRE_CHK;
            bpfa_pkg::ST_FRE_CHK:  state_next = bpfa_pkg::ST_PRIME;
            bpfa_pkg::ST_PRIME: begin
                if (stat.empty) begin
                    state_next = bpfa_pkg::ST_RESP;
                end else begin
                    state_next = bpfa_pkg::ST_WALK;
                end
            end
            bpfa_pkg::ST_WALK: begin
                case (mode_reg)
                    bpfa_pkg::MODE_ALLOC: begin
                        if (stat.hit) begin
                            state_next = bpfa_pkg::ST_PAGE;
                        end else if (stat.last_word) begin
                            state_next = bpfa_pkg::ST_RESP;
                        end
                    end
                    bpfa_pkg::MODE_RESERVE: begin
                        if (stat.last_word) begin
                            state_next = bpfa_pkg::ST_RSV_ACC;
                        end
                    end
                    default: state_next = bpfa_pkg::ST_RESP;
                endcase
            end
            bpfa_pkg::ST_RSV_ACC:    state_next = bpfa_pkg::ST_RSV_COMMIT;
            bpfa_pkg::ST_RSV_COMMIT: state_next = bpfa_pkg::ST_RESP;
            bpfa_pkg::ST_PAGE:       state_next = bpfa_pkg::ST_RESP;
            bpfa_pkg::ST_RESP: begin
                if (out_free) begin
                    state_next = bpfa_pkg::ST_IDLE;
                end
            end
            default: state_next = bpfa_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        case (state_reg)
            bpfa_pkg::ST_IDLE:       cmd.load_in    = s_valid;
            bpfa_pkg::ST_INIT_SET:   cmd.init_set   = 1'b1;
            bpfa_pkg::ST_CLEAR:      cmd.clr_word   = 1'b1;
            bpfa_pkg::ST_RSV_SUM:    cmd.rsv_sum    = 1'b1;
            bpfa_pkg::ST_RSV_CLIP:   cmd.rsv_clip   = 1'b1;
            bpfa_pkg::ST_RSV_OFF:    cmd.rsv_off    = 1'b1;
            bpfa_pkg::ST_RSV_LIM:    cmd.rsv_lim    = 1'b1;
            bpfa_pkg::ST_RSV_CHK:    cmd.rsv_chk    = 1'b1;
            bpfa_pkg::ST_ALC_CHK:    cmd.alc_chk    = 1'b1;
            bpfa_pkg::ST_FRE_OFF:    cmd.fre_off    = 1'b1;
            bpfa_pkg::ST_FRE_CHK:    cmd.fre_chk    = 1'b1;
            bpfa_pkg::ST_PRIME:      cmd.prime      = 1'b1;
            bpfa_pkg::ST_WALK:       cmd.walk       = 1'b1;
            bpfa_pkg::ST_RSV_COMMIT: cmd.rsv_commit = 1'b1;
            bpfa_pkg::ST_PAGE:       cmd.page_calc  = 1'b1;
            bpfa_pkg::ST_RESP:       cmd.load_out   = out_free;
            default:                 cmd = '0;
        endcase
    end

    always_comb begin
        mode_next    = mode_reg;
        m_valid_next = m_valid_reg;
        if (cmd.load_in) begin
            mode_next = bpfa_pkg::mode_t'(s_mode);
        end
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bpfa_pkg::ST_IDLE;
            mode_reg    <= bpfa_pkg::MODE_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == bpfa_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;

`ifndef SYNTHESIS
    a_rise_from_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == bpfa_pkg::ST_RESP))
        else $error("result raised outside the response step");
`endif

endmodule

[rtl/bpfa_datapath.sv]
`timescale 1ns / 1ps
// Datapath: config registers, range arithmetic, bitmap word walk, counters.
// Depends on bpfa_pkg and bpfa_ram; commanded by bpfa_ctrl.
module bpfa_datapath #(
    parameter int FRAMES = bpfa_pkg::FRAMES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [bpfa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bpfa_pkg::ADDR_W-1:0]       cfg_wdata,
    input  logic [bpfa_pkg::MODE_W-1:0]       s_mode,
    input  logic [bpfa_pkg::ADDR_W-1:0]       s_address,
    input  logic [bpfa_pkg::ADDR_W-1:0]       s_byte_count,
    input  bpfa_pkg::cmd_t                    cmd,
    output bpfa_pkg::stat_t                   stat,
    output logic [bpfa_pkg::STATUS_W-1:0]     m_status,
    output logic [bpfa_pkg::ADDR_W-1:0]       m_page_address,
    output logic [bpfa_pkg::OUT_CNT_W-1:0]    m_free_count
);

    localparam int WORDS  = (FRAMES + bpfa_pkg::MAP_W - 1) / bpfa_pkg::MAP_W;
    localparam int WA_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int FI_W   = WA_W + bpfa_pkg::BIT_W;
    localparam int CW_MIN = $clog2(FRAMES + 1);
    localparam int CW     = (CW_MIN > bpfa_pkg::OUT_CNT_W) ? CW_MIN : bpfa_pkg::OUT_CNT_W;
    localparam int AW     = bpfa_pkg::ADDR_W;
    localparam int MW     = bpfa_pkg::MAP_W;
    localparam int BW     = bpfa_pkg::BIT_W;
    localparam int SH     = bpfa_pkg::FRAME_SHIFT;

    // SWAR population count of one bitmap word
    function automatic logic [BW:0] pop64(input logic [63:0] x);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        a = x - ((x >> 1) & 64'h5555_5555_5555_5555);
        b = (a & 64'h3333_3333_3333_3333) + ((a >> 2) & 64'h3333_3333_3333_3333);
        c = (b + (b >> 4)) & 64'h0F0F_0F0F_0F0F_0F0F;
        c = c + (c >> 8);
        c = c + (c >> 16);
        c = c + (c >> 32);
        return c[BW:0];
    endfunction

    logic [AW-1:0]          ram_base_reg, ram_base_next;
    logic [AW-1:0]          ram_size_reg, ram_size_next;
    bpfa_pkg::mode_t        op_reg, op_next;
    logic [AW-1:0]          addr_reg, addr_next;
    logic [AW-1:0]          len_reg, len_next;
    logic [AW-1:0]          end_reg, end_next;
    logic [AW-1:0]          soff_reg, soff_next;
    logic [AW-1:0]          eoff_reg, eoff_next;
    logic                   skip_reg, skip_next;
    logic [CW-1:0]          lim_reg, lim_next;
    logic                   empty_reg, empty_next;
    logic [WA_W-1:0]        wfirst_reg, wfirst_next;
    logic [WA_W-1:0]        wlast_reg, wlast_next;
    logic [WA_W-1:0]        word_reg, word_next;
    logic [BW-1:0]          lo_reg, lo_next;
    logic [BW-1:0]          hi_reg, hi_next;
    logic [CW-1:0]          active_reg, active_next;
    logic [CW-1:0]          free_reg, free_next;
    logic [CW-1:0]          acc_reg, acc_next;
    logic [MW-1:0]          newbits_reg, newbits_next;
    logic [FI_W-1:0]        frame_reg, frame_next;
    bpfa_pkg::status_t      status_reg, status_next;
    logic [AW-1:0]          page_reg, page_next;
    bpfa_pkg::status_t      m_status_reg, m_status_next;
    logic [AW-1:0]          m_page_reg, m_page_next;
    logic [bpfa_pkg::OUT_CNT_W-1:0] m_free_reg, m_free_next;

    logic [AW:0]            end_sum;
    logic [AW:0]            lastp_sum;
    logic [bpfa_pkg::LP_W-1:0] lastp;
    logic [bpfa_pkg::PN_W-1:0] size_pn;
    logic [bpfa_pkg::PN_W-1:0] off_pn;
    logic [FI_W-1:0]        off_fi;
    logic [FI_W-1:0]        limm1_fi;
    logic [FI_W-1:0]        actm1_fi;
    logic [MW-1:0]          word;
    logic [MW-1:0]          lo_m;
    logic [MW-1:0]          hi_m;
    logic [MW-1:0]          mask;
    logic [MW-1:0]          avail;
    logic [MW-1:0]          low;
    logic [BW-1:0]          low_idx;
    logic                   last_word;
    logic                   hit;
    logic                   ram_we;
    logic [WA_W-1:0]        ram_waddr;
    logic [MW-1:0]          ram_wdata;
    logic                   ram_re;
    logic [WA_W-1:0]        ram_raddr;

    bpfa_ram #(
        .WIDTH (MW),
        .DEPTH (WORDS)
    ) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (word)
    );

    assign end_sum   = {1'b0, addr_reg} + {1'b0, len_reg};
    assign lastp_sum = {1'b0, eoff_reg} + (AW + 1)'(bpfa_pkg::FRAME_MASK);
    assign lastp     = lastp_sum[AW:SH];
    assign size_pn   = ram_size_reg[AW-1:SH];
    assign off_pn    = soff_reg[AW-1:SH];
    assign off_fi    = FI_W'(off_pn);
    assign limm1_fi  = FI_W'(lim_reg - CW'(1));
    assign actm1_fi  = FI_W'(active_reg - CW'(1));

    // bit window of the current word
    assign last_word = (word_reg == wlast_reg);
    assign lo_m      = (word_reg == wfirst_reg) ? ({MW{1'b1}} << lo_reg) : {MW{1'b1}};
    assign hi_m      = last_word ? ({MW{1'b1}} >> (BW'(MW - 1) - hi_reg)) : {MW{1'b1}};
    assign mask      = lo_m & hi_m;
    assign avail     = ~word & mask;
    assign low       = avail & (MW'(0) - avail);

    always_comb begin
        low_idx = '0;
        for (int b = 0; b < MW; b++) begin
            if (low[b]) begin
                low_idx = low_idx | BW'(b);
            end
        end
    end

    always_comb begin
        case (op_reg)
            bpfa_pkg::MODE_ALLOC: hit = |avail;
            bpfa_pkg::MODE_FREE:  hit = |(word & mask);
            default:              hit = 1'b0;
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = word_reg;
        ram_wdata = '0;
        if (cmd.clr_word) begin
            ram_we = 1'b1;
        end else if (cmd.walk) begin
            case (op_reg)
                bpfa_pkg::MODE_RESERVE: begin
                    ram_we    = 1'b1;
                    ram_wdata = word | mask;
                end
                bpfa_pkg::MODE_ALLOC: begin
                    ram_we    = hit;
                    ram_wdata = word | low;
                end
                bpfa_pkg::MODE_FREE: begin
                    ram_we    = hit;
                    ram_wdata = word & ~mask;
                end
                default: ram_we = 1'b0;
            endcase
        end
    end

    assign ram_re    = (cmd.prime && !empty_reg) || (cmd.walk && !last_word);
    assign ram_raddr = cmd.prime ? wfirst_reg : (word_reg + WA_W'(1));

    always_comb begin
        ram_base_next = ram_base_reg;
        ram_size_next = ram_size_reg;
        op_next       = op_reg;
        addr_next     = addr_reg;
        len_next      = len_reg;
        end_next      = end_reg;
        soff_next     = soff_reg;
        eoff_next     = eoff_reg;
        skip_next     = skip_reg;
        lim_next      = lim_reg;
        empty_next    = empty_reg;
        wfirst_next   = wfirst_reg;
        wlast_next    = wlast_reg;
        word_next     = word_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        active_next   = active_reg;
        free_next     = free_reg;
        acc_next      = acc_reg + CW'(pop64(newbits_reg));
        newbits_next  = '0;
        frame_next    = frame_reg;
        status_next   = status_reg;
        page_next     = page_reg;
        m_status_next = m_status_reg;
        m_page_next   = m_page_reg;
        m_free_next   = m_free_reg;

        if (cfg_we) begin
            case (cfg_index)
                bpfa_pkg::CFG_RAM_BASE: ram_base_next = cfg_wdata;
                bpfa_pkg::CFG_RAM_SIZE: ram_size_next = cfg_wdata;
                default: ram_base_next = ram_base_reg;
            endcase
        end

        if (cmd.load_in) begin
            op_next     = bpfa_pkg::mode_t'(s_mode);
            addr_next   = s_address;
            len_next    = s_byte_count;
            acc_next    = '0;
            status_next = bpfa_pkg::STAT_DONE;
            page_next   = '0;
        end

        if (cmd.init_set) begin
            active_next = (size_pn > bpfa_pkg::PN_W'(FRAMES)) ? CW'(FRAMES) : CW'(size_pn);
            free_next   = active_next;
            word_next   = '0;
        end

        if (cmd.clr_word) begin
            word_next = word_reg + WA_W'(1);
        end

        if (cmd.rsv_sum) begin
            end_next = end_sum[AW] ? {AW{1'b1}} : end_sum[AW-1:0];
        end

        if (cmd.rsv_clip) begin
            skip_next = (end_reg <= ram_base_reg);
            soff_next = (addr_reg >= ram_base_reg) ? (addr_reg - ram_base_reg) : '0;
        end

        if (cmd.rsv_off) begin
            eoff_next = end_reg - ram_base_reg;
        end

        if (cmd.rsv_lim) begin
            lim_next = (lastp < bpfa_pkg::LP_W'(active_reg)) ? CW'(lastp) : active_reg;
        end

        if (cmd.rsv_chk) begin
            empty_next  = skip_reg || (off_pn >= bpfa_pkg::PN_W'(lim_reg));
            wfirst_next = off_fi[FI_W-1:BW];
            lo_next     = off_fi[BW-1:0];
            wlast_next  = limm1_fi[FI_W-1:BW];
            hi_next     = limm1_fi[BW-1:0];
        end

        if (cmd.alc_chk) begin
            status_next = bpfa_pkg::STAT_NONE_FREE;
            empty_next  = (active_reg == '0);
            wfirst_next = '0;
            lo_next     = '0;
            wlast_next  = actm1_fi[FI_W-1:BW];
            hi_next     = actm1_fi[BW-1:0];
        end

        if (cmd.fre_off) begin
            status_next = bpfa_pkg::STAT_REJECTED;
            skip_next   = (addr_reg < ram_base_reg);
            soff_next   = addr_reg - ram_base_reg;
        end

        if (cmd.fre_chk) begin
            empty_next  = skip_reg || (off_pn >= bpfa_pkg::PN_W'(active_reg));
            wfirst_next = off_fi[FI_W-1:BW];
            wlast_next  = off_fi[FI_W-1:BW];
            lo_next     = off_fi[BW-1:0];
            hi_next     = off_fi[BW-1:0];
        end

        if (cmd.prime) begin
            word_next = wfirst_reg;
        end

        if (cmd.walk) begin
            if (!last_word) begin
                word_next = word_reg + WA_W'(1);
            end
            case (op_reg)
                bpfa_pkg::MODE_RESERVE: newbits_next = avail;
                bpfa_pkg::MODE_ALLOC: begin
                    if (hit) begin
                        frame_next  = {word_reg, low_idx};
                        free_next   = (free_reg == '0) ? '0 : (free_reg - CW'(1));
                        status_next = bpfa_pkg::STAT_DONE;
                    end
                end
                bpfa_pkg::MODE_FREE: begin
                    if (hit) begin
                        free_next   = free_reg + CW'(1);
                        status_next = bpfa_pkg::STAT_DONE;
                    end
                end
                default: newbits_next = '0;
            endcase
        end

        if (cmd.rsv_commit) begin
            free_next = (free_reg > acc_reg) ? (free_reg - acc_reg) : '0;
        end

        if (cmd.page_calc) begin
            page_next = ram_base_reg + (AW'(frame_reg) << SH);
        end

        if (cmd.load_out) begin
            m_status_next = status_reg;
            m_page_next   = page_reg;
            m_free_next   = bpfa_pkg::OUT_CNT_W'(free_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ram_base_reg <= '0;
            ram_size_reg <= '0;
            active_reg   <= '0;
            free_reg     <= '0;
        end else begin
            ram_base_reg <= ram_base_next;
            ram_size_reg <= ram_size_next;
            active_reg   <= active_next;
            free_reg     <= free_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        addr_reg     <= addr_next;
        len_reg      <= len_next;
        end_reg      <= end_next;
        soff_reg     <= soff_next;
        eoff_reg     <= eoff_next;
        skip_reg     <= skip_next;
        lim_reg      <= lim_next;
        empty_reg    <= empty_next;
        wfirst_reg   <= wfirst_next;
        wlast_reg    <= wlast_next;
        word_reg     <= word_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        acc_reg      <= acc_next;
        newbits_reg  <= newbits_next;
        frame_reg    <= frame_next;
        status_reg   <= status_next;
        page_reg     <= page_next;
        m_status_reg <= m_status_next;
        m_page_reg   <= m_page_next;
        m_free_reg   <= m_free_next;
    end

    assign stat.empty     = empty_reg;
    assign stat.last_word = last_word;
    assign stat.hit       = hit;
    assign stat.clr_last  = (word_reg == WA_W'(WORDS - 1));

    assign m_status       = m_status_reg;
    assign m_page_address = m_page_reg;
    assign m_free_count   = m_free_reg;

`ifndef SYNTHESIS
    a_free_le_active: assert property (@(posedge aclk) disable iff (!aresetn)
        free_reg <= active_reg)
        else $error("free count above frame count");

    a_no_rw_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("bitmap read and write hit the same word");

    a_walk_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.walk |-> ((word_reg >= wfirst_reg) && (word_reg <= wlast_reg)))
        else $error("word walk left its window");
`endif

endmodule

[rtl/bitmap_page_frame_allocator.sv]
`timescale 1ns / 1ps
// First-fit bitmap allocator of 4096-byte frames, one item at a time. The bitmap
// lives in a RAM of 64-bit words and is walked one word per cycle: init clears
// the whole map, allocate scans words up to the first free frame (at most
// ceil(active frames / 64) words), reserve walks every word the range spans, and
// free checks the single word of its frame. A result waits in an output register;
// the next item is accepted while it waits. ram_base is used live by reserve,
// allocate and free, ram_size only by init.
// Depends on bpfa_pkg, bpfa_ctrl, bpfa_datapath and bpfa_ram.
module bitmap_page_frame_allocator #(
    parameter int FRAMES = bpfa_pkg::FRAMES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [bpfa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bpfa_pkg::ADDR_W-1:0]       cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [bpfa_pkg::MODE_W-1:0]       s_mode,
    input  logic [bpfa_pkg::ADDR_W-1:0]       s_address,
    input  logic [bpfa_pkg::ADDR_W-1:0]       s_byte_count,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [bpfa_pkg::STATUS_W-1:0]     m_status,
    output logic [bpfa_pkg::ADDR_W-1:0]       m_page_address,
    output logic [bpfa_pkg::OUT_CNT_W-1:0]    m_free_count
);

    bpfa_pkg::cmd_t  cmd;
    bpfa_pkg::stat_t stat;

    bpfa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_mode  (s_mode),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    bpfa_datapath #(
        .FRAMES (FRAMES)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_mode         (s_mode),
        .s_address      (s_address),
        .s_byte_count   (s_byte_count),
        .cmd            (cmd),
        .stat           (stat),
        .m_status       (m_status),
        .m_page_address (m_page_address),
        .m_free_count   (m_free_count)
    );

endmodule
